[rtl/acfp_pkg.sv]
// Package for the ASCII CAN frame parser.
// Holds line limits, the queue entry and result types; imported by all modules.
// No dependencies.
package acfp_pkg;

    localparam int LINE_CAPACITY = 64;
    localparam int CNT_W         = $clog2(LINE_CAPACITY);
    localparam int MIN_LINE      = 11;
    localparam int ID_LAST_POS   = 8;
    localparam int LEN_POS       = 9;
    localparam int DATA_START    = 10;
    localparam int MAX_LEN       = 8;
    localparam int PGN_W         = 17;
    localparam int PGN_SHIFT     = 8;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] CHAR_T  = 8'h54;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    localparam int OUT_BITS = 32 + 4 + 32 + 32 + PGN_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic       is_lf;
        logic       is_t;
        logic       hex_ok;
        logic [3:0] nib;
    } char_class_t;

    typedef struct packed {
        logic [PGN_W-1:0] pgn;
        logic [31:0]      data_high;
        logic [31:0]      data_low;
        logic [3:0]       frame_len;
        logic [31:0]      frame_id;
    } frame_t;

endpackage

[rtl/acfp_front.sv]
// Front stage of the ASCII CAN frame parser: classifies each received byte.
// Drops carriage returns and pushes every other byte into the queue.
// Depends on acfp_pkg.
module acfp_front
    import acfp_pkg::*;
(
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // rx_byte[7:0]
    input  logic        q_full,
    output logic        push,
    output char_class_t push_data
);

    logic [3:0] nib;
    logic       hex_ok;

    always_comb
    begin
        nib    = 4'd0;
        hex_ok = 1'b0;
        if (s_tdata >= 8'h30 && s_tdata <= 8'h39)
        begin
            nib    = 4'(s_tdata - 8'h30);
            hex_ok = 1'b1;
        end
        else if (s_tdata >= 8'h41 && s_tdata <= 8'h46)
        begin
            nib    = 4'(s_tdata - 8'h37);
            hex_ok = 1'b1;
        end
        else if (s_tdata >= 8'h61 && s_tdata <= 8'h66)
        begin
            nib    = 4'(s_tdata - 8'h57);
            hex_ok = 1'b1;
        end
    end

    assign s_tready         = !q_full;
    assign push             = s_tvalid && !q_full && (s_tdata != CHAR_CR);
    assign push_data.is_lf  = (s_tdata == CHAR_LF);
    assign push_data.is_t   = (s_tdata == CHAR_T);
    assign push_data.hex_ok = hex_ok;
    assign push_data.nib    = nib;

endmodule

[rtl/acfp_queue.sv]
// Short queue between the classifying front and the parsing back.
// Register-based FIFO of QUEUE_DEPTH classified characters.
// Depends on acfp_pkg.
module acfp_queue
    import acfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  char_class_t push_data,
    output logic        full,
    input  logic        pop,
    output logic        q_valid,
    output char_class_t q_data
);

    char_class_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]       wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]       count_reg, count_next;
    logic                    do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_data  = entry_reg[rd_ptr_reg];
    assign do_pop  = pop && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count out of range");

    a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not advance on push");

endmodule

[rtl/acfp_back.sv]
// Back stage of the ASCII CAN frame parser: walks the line position by position.
// Builds identifier, length and data bytes and holds the finished frame.
// Depends on acfp_pkg.
module acfp_back
    import acfp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  char_class_t q_data,
    output logic        pop,
    output logic        out_valid,
    input  logic        out_ready,
    output frame_t      out_frame
);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [31:0]      id_reg, id_next;
    logic [3:0]       len_reg, len_next;
    logic [7:0]       data_reg [8];
    logic [7:0]       data_next [8];
    logic             bad_reg, bad_next;
    logic             out_valid_reg, out_valid_next;
    frame_t           out_frame_reg, out_frame_next;

    logic [CNT_W-1:0] need;
    logic [CNT_W-1:0] off;
    logic [2:0]       idx;
    logic             line_ok;
    logic [31:0]      lo_bytes;
    logic [31:0]      hi_bytes;

    assign pop       = q_valid && (!q_data.is_lf || !out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign out_frame = out_frame_reg;

    assign need    = CNT_W'(DATA_START) + CNT_W'({len_reg, 1'b0});
    assign off     = cnt_reg - CNT_W'(DATA_START);
    assign idx     = off[3:1];
    assign line_ok = !bad_reg && (cnt_reg >= CNT_W'(MIN_LINE)) && (cnt_reg >= need);

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            lo_bytes[8*i +: 8] = (4'(i) < len_reg) ? data_reg[i] : 8'd0;
            hi_bytes[8*i +: 8] = (4'(i + 4) < len_reg) ? data_reg[i + 4] : 8'd0;
        end
    end

    always_comb
    begin
        cnt_next       = cnt_reg;
        id_next        = id_reg;
        len_next       = len_reg;
        bad_next       = bad_reg;
        data_next      = data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_frame_next = out_frame_reg;
        if (pop)
        begin
            if (q_data.is_lf || cnt_reg >= CNT_W'(LINE_CAPACITY - 1) || cnt_reg == '0)
            begin
                cnt_next  = '0;
                id_next   = '0;
                len_next  = '0;
                bad_next  = 1'b0;
                for (int i = 0; i < 8; i++)
                begin
                    data_next[i] = 8'd0;
                end
            end
            if (q_data.is_lf)
            begin
                if (line_ok)
                begin
                    out_valid_next           = 1'b1;
                    out_frame_next.frame_id  = id_reg;
                    out_frame_next.frame_len = len_reg;
                    out_frame_next.data_low  = lo_bytes;
                    out_frame_next.data_high = hi_bytes;
                    out_frame_next.pgn       = id_reg[PGN_SHIFT +: PGN_W];
                end
            end
            else if (cnt_reg < CNT_W'(LINE_CAPACITY - 1))
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == '0)
                begin
                    bad_next = !q_data.is_t;
                end
                else if (cnt_reg <= CNT_W'(ID_LAST_POS))
                begin
                    if (!q_data.hex_ok)
                    begin
                        bad_next = 1'b1;
                    end
                    else
                    begin
                        id_next = {id_reg[27:0], q_data.nib};
                    end
                end
                else if (cnt_reg == CNT_W'(LEN_POS))
                begin
                    if (!q_data.hex_ok || q_data.nib > 4'(MAX_LEN))
                    begin
                        bad_next = 1'b1;
                    end
                    else
                    begin
                        len_next = q_data.nib;
                    end
                end
                else if (cnt_reg < need)
                begin
                    if (!q_data.hex_ok)
                    begin
                        bad_next = 1'b1;
                    end
                    else if (!off[0])
                    begin
                        data_next[idx] = {q_data.nib, 4'd0};
                    end
                    else
                    begin
                        data_next[idx] = data_reg[idx] | {4'd0, q_data.nib};
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            id_reg        <= '0;
            len_reg       <= '0;
            bad_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                data_reg[i] <= 8'd0;
            end
        end
        else
        begin
            cnt_reg       <= cnt_next;
            id_reg        <= id_next;
            len_reg       <= len_next;
            bad_reg       <= bad_next;
            out_valid_reg <= out_valid_next;
            data_reg      <= data_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_frame_reg <= out_frame_next;
    end

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(LINE_CAPACITY - 1))
        else $error("line position beyond capacity");

    a_frame_from_lf: assert property (@(posedge clk) disable iff (!rst_n)
        (!out_valid_reg || out_ready) && !(pop && q_data.is_lf) |=> !out_valid_reg)
        else $error("frame raised without a newline");

    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= 4'(MAX_LEN))
        else $error("length beyond limit");

endmodule

[rtl/ascii_can_frame_parser_unit.sv]
// ASCII CAN frame parser (serial-line extended frame form).
// Channels: s_* carries one received character per transfer; m_* carries one
// parsed frame per transfer, sent when a newline ends a well-formed line.
// A frame is raised on m_tvalid once the newline has passed the queue and then
// the parse step, which loads the output register.
// Throughput: one character per cycle while s_tready is high; the back stage pops
// one queue entry per cycle through its single parse step per character, unless a newline finds the output held.
// Carriage returns are dropped at the front and never reach the queue.
// A two-entry queue decouples the classifier from the parser; the frame sits
// in an output register, so the parser keeps taking characters while a frame
// waits, and only a newline that finds the output still held stalls it.
// When the receiver stalls, that newline and one more character fill the
// queue and s_tready drops until the held frame is taken.
// Reset: clears the line position, identifier, length, data bytes, bad flag,
// the queue and the output valid; no frame is pending afterward.
// Depends on acfp_pkg, acfp_front, acfp_queue, acfp_back.
module ascii_can_frame_parser_unit
    import acfp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,   // rx_byte[7:0]
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata    // frame_id, frame_len, data_low, data_high, pgn, pad
);

    logic        q_full;
    logic        push;
    char_class_t push_data;
    logic        pop;
    logic        q_valid;
    char_class_t q_data;
    frame_t      out_frame;

    acfp_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .push      (push),
        .push_data (push_data)
    );

    acfp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_data    (q_data)
    );

    acfp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_frame (out_frame)
    );

    assign m_tdata = {(OUT_W - OUT_BITS)'(0), out_frame};

endmodule
